>>> src/slt_pkg.sv
`default_nettype none
package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PLACE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [IW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic signed [DW-1:0] read_value;
    logic [CW-1:0]        count;
  } res_t;

endpackage
`default_nettype wire

>>> src/sorted_list_table.sv
// Sorted table, one request at a time via one compare unit and a two-port RAM.
// A read does one RAM read; delete scans every entry; insert scans from the top
// entry down to its place (each scan step is a RAM read, then a compare); full,
// empty and invalid requests finish without a scan. in_ready is low while a
// request runs or its result waits for transfer.
// Reset clears the entry count and control; table contents are not cleared.
`default_nettype none
module sorted_list_table
  import slt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [1:0]           action,
  input  wire logic signed [DW-1:0] value,
  input  wire logic [CW-1:0]        position,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [1:0]           status,
  output      logic signed [DW-1:0] read_value,
  output      logic [CW-1:0]        entry_count
);

  ram_req_t             req;
  res_t                 res;
  cmp_t                 cmp;
  logic [DW-1:0]        rdata;
  logic signed [DW-1:0] key;
  logic                 idle;
  logic                 start;

  assign in_ready = idle && !out_valid;
  assign start    = in_valid && in_ready;

  slt_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .re   (req.re),
    .raddr(req.raddr),
    .rdata(rdata)
  );

  slt_cmp u_cmp (
    .a  (rdata),
    .b  (key),
    .res(cmp)
  );

  slt_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .value   (value),
    .position(position),
    .rdata   (rdata),
    .cmp     (cmp),
    .key     (key),
    .req     (req),
    .res     (res),
    .idle    (idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res.valid) begin
      status      <= res.status;
      read_value  <= res.read_value;
      entry_count <= res.count;
    end
  end

endmodule
`default_nettype wire

>>> src/slt_ram.sv
`default_nettype none
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/slt_cmp.sv
`default_nettype none
module slt_cmp
  import slt_pkg::*;
(
  input  wire logic signed [DW-1:0] a,
  input  wire logic signed [DW-1:0] b,
  output      cmp_t                 res
);

  always_comb begin
    res.gt = a > b;
    res.eq = a == b;
  end

endmodule
`default_nettype wire

>>> src/slt_seq.sv
`default_nettype none
module slt_seq
  import slt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           action,
  input  wire logic signed [DW-1:0] value,
  input  wire logic [CW-1:0]        position,
  input  wire logic [DW-1:0]        rdata,
  input  wire cmp_t                 cmp,
  output      logic signed [DW-1:0] key,
  output      ram_req_t             req,
  output      res_t                 res,
  output      logic                 idle
);

  state_t               state, state_next;
  action_t              act, act_next;
  logic signed [DW-1:0] key_next;
  logic [IW-1:0]        idx, idx_next;
  logic [CW-1:0]        count, count_next;
  logic                 found, found_next;
  status_t              status, status_next;
  logic signed [DW-1:0] rd, rd_next;

  logic [CW-1:0] pos_m1;
  logic [CW-1:0] cnt_m1;
  logic          is_full;
  logic          is_empty;
  logic          bad_pos;
  logic          last;

  assign pos_m1   = position - CW'(1);
  assign cnt_m1   = count - CW'(1);
  assign is_full  = count >= CW'(CAPACITY);
  assign is_empty = count == '0;
  assign bad_pos  = (position == '0) || (position > count);
  assign last     = idx == cnt_m1[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    act    <= act_next;
    key    <= key_next;
    idx    <= idx_next;
    found  <= found_next;
    status <= status_next;
    rd     <= rd_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action_t'(action))
            ACT_INSERT: state_next = (is_full || is_empty) ? S_FINISH : S_READ;
            ACT_DELETE: state_next = is_empty ? S_FINISH : S_READ;
            ACT_READ:   state_next = bad_pos ? S_FINISH : S_READ;
            default:    state_next = S_FINISH;
          endcase
        end
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        case (act)
          ACT_INSERT: begin
            if (cmp.gt) begin
              state_next = (idx == '0) ? S_PLACE : S_READ;
            end else begin
              state_next = S_FINISH;
            end
          end
          ACT_DELETE: state_next = last ? S_FINISH : S_READ;
          default:    state_next = S_FINISH;
        endcase
      end
      S_PLACE:  state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    act_next    = act;
    key_next    = key;
    idx_next    = idx;
    count_next  = count;
    found_next  = found;
    status_next = status;
    rd_next     = rd;
    req         = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          act_next    = action_t'(action);
          key_next    = value;
          found_next  = 1'b0;
          status_next = ST_OK;
          rd_next     = '0;
          case (action_t'(action))
            ACT_INSERT: begin
              if (is_full) begin
                status_next = ST_FULL;
              end else if (is_empty) begin
                req.we     = 1'b1;
                req.waddr  = '0;
                req.wdata  = value;
                count_next = count + CW'(1);
              end else begin
                idx_next = cnt_m1[IW-1:0];
              end
            end
            ACT_DELETE: begin
              if (is_empty) begin
                status_next = ST_NOT_FOUND;
              end
              idx_next = '0;
            end
            ACT_READ: begin
              if (bad_pos) begin
                status_next = ST_BAD_POS;
              end
              idx_next = pos_m1[IW-1:0];
            end
            default: status_next = ST_BAD_POS;
          endcase
        end
      end
      S_READ: begin
        req.re    = 1'b1;
        req.raddr = idx;
      end
      S_EVAL: begin
        case (act)
          ACT_INSERT: begin
            req.we    = 1'b1;
            req.waddr = idx + IW'(1);
            if (cmp.gt) begin
              req.wdata = rdata;
              idx_next  = idx - IW'(1);
            end else begin
              req.wdata  = key;
              count_next = count + CW'(1);
            end
          end
          ACT_DELETE: begin
            if (found) begin
              req.we    = 1'b1;
              req.waddr = idx - IW'(1);
              req.wdata = rdata;
            end
            found_next = found || cmp.eq;
            idx_next   = idx + IW'(1);
            if (last) begin
              if (found || cmp.eq) begin
                count_next = cnt_m1;
              end else begin
                status_next = ST_NOT_FOUND;
              end
            end
          end
          default: rd_next = rdata;
        endcase
      end
      S_PLACE: begin
        req.we     = 1'b1;
        req.waddr  = '0;
        req.wdata  = key;
        count_next = count + CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    idle           = state == S_IDLE;
    res.valid      = state == S_FINISH;
    res.status     = status;
    res.read_value = rd;
    res.count      = count;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_EVAL)
    else $error("compare step without a preceding read");

  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && status == ST_FULL) |-> count == CW'(CAPACITY))
    else $error("full reported below capacity");

  a_place_bottom: assert property (@(posedge clk) disable iff (rst)
    state == S_PLACE |-> (act == ACT_INSERT && $past(idx) == '0))
    else $error("bottom placement outside insert");

endmodule
`default_nettype wire
